// ----- src/utf8_stream_decoder_defines.svh -----
// Assertion macros used by the UTF-8 stream decoder checker.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define UTF8_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define UTF8_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that stays active through reset.
`define UTF8_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/utf8_dec_pkg.sv -----
// Types, codes and lookup functions of the UTF-8 stream decoder.
`default_nettype none

package utf8_dec_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned CpW   = 21;

   typedef enum logic [1:0] {
      STATUS_PENDING = 2'd0,
      STATUS_DONE    = 2'd1,
      STATUS_BAD     = 2'd2
   } status_type;

   // Decoder states: how many continuation bytes are due and which range the next may take.
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_ONE      = 3'd1,
      ST_TWO      = 3'd2,
      ST_TWO_ED   = 3'd3,
      ST_THREE_F4 = 3'd4,
      ST_THREE    = 3'd5,
      ST_TWO_E0   = 3'd6,
      ST_THREE_F0 = 3'd7
   } decode_state_type;

   // Lead byte classes; class minus one is the entry state, 0xFF >> class the payload mask.
   localparam logic [3:0] CLS_INVALID = 4'd1;
   localparam logic [3:0] CLS_TWO     = 4'd2;
   localparam logic [3:0] CLS_THREE   = 4'd3;
   localparam logic [3:0] CLS_ED      = 4'd4;
   localparam logic [3:0] CLS_F4      = 4'd5;
   localparam logic [3:0] CLS_FOUR    = 4'd6;
   localparam logic [3:0] CLS_E0      = 4'd7;
   localparam logic [3:0] CLS_F0      = 4'd8;

   typedef struct packed {
      logic             reject;
      decode_state_type state;
   } next_type;

   typedef struct packed {
      decode_state_type   state;
      logic [CpW-1:0]     acc;
      status_type         status;
      logic [CpW-1:0]     code_point;
   } step_type;

   // Class of bytes 0xC0..0xFF, indexed by the low six bits.
   function automatic logic [3:0] lead_class(input logic [5:0] idx);
      logic [3:0] cls;
      priority if (idx < 6'd2)   cls = CLS_INVALID;
      else if (idx < 6'd32)      cls = CLS_TWO;
      else if (idx == 6'd32)     cls = CLS_E0;
      else if (idx == 6'd45)     cls = CLS_ED;
      else if (idx < 6'd48)      cls = CLS_THREE;
      else if (idx == 6'd48)     cls = CLS_F0;
      else if (idx < 6'd52)      cls = CLS_FOUR;
      else if (idx == 6'd52)     cls = CLS_F4;
      else                       cls = CLS_INVALID;
      return cls;
   endfunction

   // Next state per state and continuation group (byte bits 5..4).
   function automatic next_type next_state(input decode_state_type st, input logic [1:0] grp);
      next_type nx;
      nx.reject = 1'b0;
      nx.state  = ST_IDLE;
      unique case (st)
         ST_IDLE:     nx.reject = 1'b1;
         ST_ONE:      nx.state  = ST_IDLE;
         ST_TWO:      nx.state  = ST_ONE;
         ST_TWO_ED: begin
            nx.state  = ST_ONE;
            nx.reject = grp[1];
         end
         ST_THREE_F4: begin
            nx.state  = ST_TWO;
            nx.reject = (grp != 2'd0);
         end
         ST_THREE:    nx.state  = ST_TWO;
         ST_TWO_E0: begin
            nx.state  = ST_ONE;
            nx.reject = !grp[1];
         end
         ST_THREE_F0: begin
            nx.state  = ST_TWO;
            nx.reject = (grp == 2'd0);
         end
      endcase
      return nx;
   endfunction

endpackage

`default_nettype wire

// ----- src/utf8_stream_decoder.sv -----
// UTF-8 stream decoder top level: input register, decode step, result register.
// Takes one byte per item and gives one result per byte: pending, a complete
// code point, or malformed. Sustains one item per clock while rsp_stall is low;
// an accepted byte is registered in the input register, decoded against the
// held state, and its result is registered in the result register, from
// which rsp_valid is driven. The rate is set by the state and accumulator
// loop, one table step and a six-bit shift per cycle. rsp_stall backs up
// into req_stall only when both registers are full.
`default_nettype none

module utf8_stream_decoder
   import utf8_dec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ByteW-1:0]  req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [CpW-1:0]    rsp_code_point
);

   logic              in_valid_ff;
   logic [ByteW-1:0]  in_byte_ff;
   decode_state_type  state_ff;
   logic [CpW-1:0]    acc_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [CpW-1:0]    rsp_cp_ff;
   logic              advance;
   step_type          step;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   utf8_dec_step u_step (
      .in_byte (in_byte_ff),
      .state   (state_ff),
      .acc     (acc_ff),
      .step    (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               state_ff <= step.state;
               acc_ff   <= step.acc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && in_valid_ff) begin
         rsp_status_ff <= step.status;
         rsp_cp_ff     <= step.code_point;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_code_point = rsp_cp_ff;

endmodule

`default_nettype wire

// ----- src/utf8_dec_step.sv -----
// One decode step: byte, state and accumulator in; next state, accumulator and result out.
`default_nettype none

module utf8_dec_step
   import utf8_dec_pkg::*;
(
   input  logic [ByteW-1:0]  in_byte,
   input  decode_state_type  state,
   input  logic [CpW-1:0]    acc,
   output step_type          step
);

   next_type          nx;
   logic [3:0]        cls;
   logic [CpW-1:0]    shifted;
   logic [ByteW-1:0]  lead_bits;

   assign nx        = next_state(state, in_byte[5:4]);
   assign cls       = lead_class(in_byte[5:0]);
   assign shifted   = {acc[CpW-7:0], in_byte[5:0]};
   assign lead_bits = in_byte & (8'hFF >> cls);

   always_comb begin
      step.state      = ST_IDLE;
      step.acc        = '0;
      step.status     = STATUS_BAD;
      step.code_point = '0;
      priority if (!in_byte[7]) begin
         if (state == ST_IDLE) begin
            step.status     = STATUS_DONE;
            step.code_point = {{(CpW-ByteW){1'b0}}, in_byte};
         end
      end else if (state != ST_IDLE) begin
         if (!in_byte[6] && !nx.reject) begin
            if (nx.state == ST_IDLE) begin
               step.status     = STATUS_DONE;
               step.code_point = shifted;
            end else begin
               step.status = STATUS_PENDING;
               step.state  = nx.state;
               step.acc    = shifted;
            end
         end
      end else if (in_byte[6] && (cls != CLS_INVALID)) begin
         step.status = STATUS_PENDING;
         step.state  = decode_state_type'(3'(cls - 4'd1));
         step.acc    = {{(CpW-ByteW){1'b0}}, lead_bits};
      end else begin
         // stray continuation or invalid lead byte
         step.status = STATUS_BAD;
      end
   end

endmodule

`default_nettype wire

// ----- src/utf8_dec_checker.sv -----
// Port-level assertions for the UTF-8 stream decoder and their bind.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module utf8_dec_checker
   import utf8_dec_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [ByteW-1:0]  req_in_byte,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_status,
   input logic [CpW-1:0]    rsp_code_point
);

   logic is_done;
   logic ok_scalar;
   logic unused_req;

   assign is_done    = (rsp_status == STATUS_DONE);
   assign ok_scalar  = (rsp_code_point <= 21'h10FFFF) &&
                       !((rsp_code_point >= 21'h00D800) && (rsp_code_point <= 21'h00DFFF));
   assign unused_req = req_valid ^ req_stall ^ (^req_in_byte);

   `UTF8_ASSERT_RESET(a_reset_empty, reset, !rsp_valid, "result valid right after reset")
   `UTF8_ASSERT_NOW(a_zero_cp, rsp_valid && !is_done, rsp_code_point == '0, "code point not zero")
   `UTF8_ASSERT_NOW(a_scalar, rsp_valid && is_done, ok_scalar, "code point not a scalar value")
   `UTF8_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall && !unused_req ^ unused_req,
      rsp_valid && $stable(rsp_status) && $stable(rsp_code_point), "stalled result changed")

endmodule

bind utf8_stream_decoder utf8_dec_checker u_utf8_dec_checker (.*);

`default_nettype wire
